// ===== rtl/mwer_pkg.sv =====
// ---------------------------------------------------------------------------
// mwer_pkg
// Shared types and constants of the multi-window EMA rate meter.
// ---------------------------------------------------------------------------
`default_nettype none
package mwer_pkg;
	localparam int CountW  = 48;
	localparam int TimeW   = 62;
	localparam int WinW    = 36;
	localparam int RateW   = 48;
	localparam int NumCfg  = 4;
	localparam int CfgIdxW = 2;

	typedef enum logic [1:0] {
		ST_FIRST   = 2'd0,
		ST_UPDATED = 2'd1,
		ST_STALE   = 2'd2
	} status_t;

	localparam logic [WinW-1:0] WinReset0 = 36'd60000000;
	localparam logic [WinW-1:0] WinReset1 = 36'd300000000;
	localparam logic [WinW-1:0] WinReset2 = 36'd900000000;
	localparam logic [WinW-1:0] WinReset3 = 36'd3600000000;

	localparam logic [16:0] Log2eQ16 = 17'd94548;
	localparam logic [16:0] OneQ16   = 17'd65536;
	localparam logic [19:0] UsPerSec = 20'd1000000;

	function automatic logic [16:0] poly_coef(input logic [2:0] k);
		case (k)
			3'd0:    poly_coef = 17'd87;
			3'd1:    poly_coef = 17'd630;
			3'd2:    poly_coef = 17'd3638;
			3'd3:    poly_coef = 17'd15744;
			3'd4:    poly_coef = 17'd45426;
			3'd5:    poly_coef = 17'd65536;
			default: poly_coef = 17'd0;
		endcase
	endfunction
endpackage
`default_nettype wire

// ===== rtl/mwer_if.sv =====
// ---------------------------------------------------------------------------
// mwer_in_if / mwer_out_if
// Valid/ready channels of the rate meter.
// ---------------------------------------------------------------------------
`default_nettype none
interface mwer_in_if;
	logic                 valid;
	logic                 ready;
	logic signed [47:0]   sample_count;
	logic        [61:0]   sample_time_us;
	modport source (output valid, sample_count, sample_time_us, input ready);
	modport sink   (input valid, sample_count, sample_time_us, output ready);
endinterface

interface mwer_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  window_index;
	logic [47:0] window_rate;
	logic        rate_ready;
	logic [47:0] instant_rate;
	logic [1:0]  sample_status;
	logic        last_of_run;
	modport source (output valid, window_index, window_rate, rate_ready, instant_rate,
		sample_status, last_of_run, input ready);
	modport sink   (input valid, window_index, window_rate, rate_ready, instant_rate,
		sample_status, last_of_run, output ready);
endinterface
`default_nettype wire

// ===== rtl/multi_window_ema_rate_meter.sv =====
// ---------------------------------------------------------------------------
// multi_window_ema_rate_meter
// Multi-window EMA rate meter over irregularly timed counter samples.
// ---------------------------------------------------------------------------
//  channel  dir  word
//  in       in   sample_count, sample_time_us
//  out      out  window_index, window_rate, rate_ready, instant_rate, status, last
//  cfg      in   cfg_we, cfg_idx, cfg_data (window lengths)
//
// An updating sample runs the rate division and then, per window, the decay
// division and polynomial steps, all on one bit-serial divider and one
// multiplier. First and stale samples skip both and go straight to output.
// Then NUM_WINDOWS words leave, one per accepted out handshake.
// Input is not ready until the last word of the run is taken.
// ---------------------------------------------------------------------------
`default_nettype none
module multi_window_ema_rate_meter #(
	parameter int NUM_WINDOWS    = 4,
	parameter int RATE_FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	mwer_in_if.sink          in_ch,
	mwer_out_if.source       out_ch,
	input  wire logic        cfg_we,
	input  wire logic [mwer_pkg::CfgIdxW-1:0] cfg_idx,
	input  wire logic [mwer_pkg::WinW-1:0]    cfg_data
);
	localparam int WIdxW = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;
	localparam int RW    = mwer_pkg::RateW;

	typedef enum logic [3:0] {
		S_IDLE, S_DIV_RATE, S_RATE_DONE, S_WIN_CHK, S_DIV_DEC, S_EXP_Y,
		S_POLY, S_MIX_A, S_MIX_B, S_NEXT, S_OUT
	} state_t;

	state_t state_q;
	logic [mwer_pkg::WinW-1:0]   win_q [NUM_WINDOWS];
	logic [RW-1:0]               avg_q [NUM_WINDOWS];
	logic                        seen_q;
	logic [47:0]                 prev_cnt_q;
	logic [61:0]                 prev_time_q, first_time_q, cur_time_q, dt_q;
	logic [RW-1:0]               inst_q;
	logic [1:0]                  status_q;
	logic [WIdxW-1:0]            w_q;
	logic [2:0]                  k_q;
	logic [16:0]                 p_q, f_q, d_q;
	logic [5:0]                  n_q;
	logic [80:0]                 acc_q;

	logic         div_start, div_busy;
	logic [127:0] div_num, div_quot;
	logic [61:0]  div_den;

	logic [mwer_pkg::WinW-1:0] eff_w;
	logic [47:0]  bn, bp, delta;
	logic [67:0]  dprod;
	logic         dec_zero;
	logic [RW:0]  mul_a;
	logic [32:0]  mul_b;
	logic [81:0]  mul_p;
	logic         last_w;

	assign eff_w  = (win_q[w_q] == '0) ? 36'd1 : win_q[w_q];
	assign bn     = in_ch.sample_count ^ 48'h8000_0000_0000;
	assign bp     = prev_cnt_q ^ 48'h8000_0000_0000;
	assign delta  = (bn > bp) ? (bn - bp) : '0;
	assign dprod  = delta * mwer_pkg::UsPerSec;
	assign dec_zero = {3'b000, dt_q} >= {26'd0, eff_w, 3'b000};
	assign last_w = (w_q == WIdxW'(NUM_WINDOWS - 1));

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_EXP_Y: begin
				mul_a = (RW+1)'(div_quot[31:0]);
				mul_b = 33'(mwer_pkg::Log2eQ16);
			end
			S_POLY: begin
				mul_a = (RW+1)'(f_q);
				mul_b = 33'(p_q);
			end
			S_MIX_A: begin
				mul_a = {1'b0, inst_q};
				mul_b = 33'(mwer_pkg::OneQ16 - d_q);
			end
			S_MIX_B: begin
				mul_a = {1'b0, avg_q[w_q]};
				mul_b = 33'(d_q);
			end
			default: ;
		endcase
	end
	assign mul_p = mul_a * mul_b;

	assign div_start = (state_q == S_IDLE && in_ch.valid && seen_q &&
		in_ch.sample_time_us > prev_time_q) ||
		(state_q == S_WIN_CHK && !dec_zero);
	assign div_num = (state_q == S_IDLE) ?
		(128'(dprod) << RATE_FRAC_BITS) : (128'(dt_q) << 17);
	assign div_den = (state_q == S_IDLE) ? (in_ch.sample_time_us - prev_time_q)
		: 62'(eff_w);

	mwer_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_num),
		.divisor(div_den), .busy(div_busy), .quotient(div_quot)
	);

	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = (state_q == S_OUT);
	assign out_ch.window_index  = 2'(w_q);
	assign out_ch.rate_ready    = (64'(first_time_q) + 64'(eff_w)) <= 64'(cur_time_q);
	assign out_ch.window_rate   = out_ch.rate_ready ? avg_q[w_q] : '0;
	assign out_ch.instant_rate  = inst_q;
	assign out_ch.sample_status = status_q;
	assign out_ch.last_of_run   = last_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			seen_q  <= 1'b0;
			prev_cnt_q <= '0;
			prev_time_q <= '0;
			first_time_q <= '0;
			inst_q <= '0;
			for (int i = 0; i < NUM_WINDOWS; i++) begin
				avg_q[i] <= '0;
				win_q[i] <= (i == 0) ? mwer_pkg::WinReset0 : (i == 1) ? mwer_pkg::WinReset1 :
					(i == 2) ? mwer_pkg::WinReset2 : mwer_pkg::WinReset3;
			end
			w_q <= '0;
			status_q <= mwer_pkg::ST_FIRST;
		end else begin
			if (cfg_we && 32'(cfg_idx) < NUM_WINDOWS)
				win_q[WIdxW'(cfg_idx)] <= cfg_data;
			case (state_q)
				S_IDLE: if (in_ch.valid) begin
					cur_time_q <= in_ch.sample_time_us;
					w_q <= '0;
					if (!seen_q) begin
						seen_q <= 1'b1;
						prev_cnt_q <= in_ch.sample_count;
						prev_time_q <= in_ch.sample_time_us;
						first_time_q <= in_ch.sample_time_us;
						status_q <= mwer_pkg::ST_FIRST;
						state_q <= S_OUT;
					end else if (in_ch.sample_time_us <= prev_time_q) begin
						status_q <= mwer_pkg::ST_STALE;
						state_q <= S_OUT;
					end else begin
						dt_q <= in_ch.sample_time_us - prev_time_q;
						prev_cnt_q <= in_ch.sample_count;
						prev_time_q <= in_ch.sample_time_us;
						status_q <= mwer_pkg::ST_UPDATED;
						state_q <= S_DIV_RATE;
					end
				end
				S_DIV_RATE: if (!div_busy) state_q <= S_RATE_DONE;
				S_RATE_DONE: begin
					inst_q <= (div_quot[127:RW] != '0) ? {RW{1'b1}} : div_quot[RW-1:0];
					state_q <= S_WIN_CHK;
				end
				S_WIN_CHK: begin
					if (dec_zero) begin
						d_q <= '0;
						state_q <= S_MIX_A;
					end else
						state_q <= S_DIV_DEC;
				end
				S_DIV_DEC: if (!div_busy) state_q <= S_EXP_Y;
				S_EXP_Y: begin
					// quotient below 2^20 here, since dt < 8*W
					f_q <= {1'b0, 16'((mul_p + 82'd32768) >> 16)};
					n_q <= 6'((mul_p + 82'd32768) >> 32);
					p_q <= mwer_pkg::poly_coef(3'd0);
					k_q <= 3'd1;
					state_q <= S_POLY;
				end
				S_POLY: begin
					p_q <= mwer_pkg::poly_coef(k_q) - 17'(mul_p >> 16);
					if (k_q == 3'd5) state_q <= S_NEXT;
					k_q <= k_q + 3'd1;
				end
				S_NEXT: begin
					d_q <= (n_q > 6'd16) ? 17'd0 : (p_q >> n_q);
					state_q <= S_MIX_A;
				end
				S_MIX_A: begin
					acc_q <= 81'(mul_p) + 81'd32768;
					state_q <= S_MIX_B;
				end
				S_MIX_B: begin
					avg_q[w_q] <= RW'((acc_q + 81'(mul_p)) >> 16);
					if (last_w) begin
						w_q <= '0;
						state_q <= S_OUT;
					end else begin
						w_q <= w_q + 1'b1;
						state_q <= S_WIN_CHK;
					end
				end
				S_OUT: if (out_ch.ready) begin
					if (last_w) begin
						w_q <= '0;
						state_q <= S_IDLE;
					end else
						w_q <= w_q + 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_out_only_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready) else $error("output and input both open");
	a_div_idle_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !div_busy) else $error("divider busy while emitting");
	a_status_upd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MIX_B) |-> (status_q == mwer_pkg::ST_UPDATED))
		else $error("mix without update status");
endmodule
`default_nettype wire

// ===== rtl/mwer_divider.sv =====
// ---------------------------------------------------------------------------
// mwer_divider
// Restoring divider, one quotient bit per cycle, 128-bit dividend.
// ---------------------------------------------------------------------------
`default_nettype none
module mwer_divider (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [127:0] dividend,
	input  wire logic [61:0]  divisor,
	output logic              busy,
	output logic [127:0]      quotient
);
	logic [62:0]  rem_q;
	logic [127:0] num_q;
	logic [61:0]  den_q;
	logic [7:0]   cnt_q;
	logic [62:0]  trial;
	logic         fits;

	assign trial = {rem_q[61:0], num_q[127]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy  <= 1'b1;
			cnt_q <= 8'd128;
		end else if (busy) begin
			cnt_q <= cnt_q - 8'd1;
			if (cnt_q == 8'd1)
				busy <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= dividend;
			den_q <= divisor;
		end else if (busy) begin
			rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
			num_q <= {num_q[126:0], fits};
		end
	end

	assign quotient = num_q;
endmodule
`default_nettype wire

// ===== tb/mwer_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// mwer_checker
// Watches the sample, result and window-register ports of the rate meter,
// keeps its own copy of the meter state, predicts the four result words of
// every accepted sample and compares them in order with the words taken.
// ---------------------------------------------------------------------------
module mwer_checker (
	input  logic        clk,
	input  logic        arst_n,
	mwer_in_if          in_ch,
	mwer_out_if         out_ch,
	input  logic        cfg_we,
	input  logic [mwer_pkg::CfgIdxW-1:0] cfg_idx,
	input  logic [mwer_pkg::WinW-1:0]    cfg_data,
	output int          fails,
	output int          pending,
	output int          n_samples,
	output int          n_words
);
	localparam int NWin = 4;
	localparam logic [47:0] RateMax = 48'hFFFF_FFFF_FFFF;
	localparam logic [47:0] SignBit = 48'h8000_0000_0000;

	typedef struct packed {
		logic [1:0]  window_index;
		logic [47:0] window_rate;
		logic        rate_ready;
		logic [47:0] instant_rate;
		mwer_pkg::status_t sample_status;
		logic        last_of_run;
	} rate_word_t;

	rate_word_t  expected_words[$];
	logic [35:0] win_len[NWin];
	logic        seen;
	logic [47:0] last_count;
	logic [61:0] last_time;
	logic [61:0] start_time;
	logic [47:0] inst_rate;
	logic [47:0] avg_rate[NWin];

	function automatic logic [63:0] eff_len(logic [35:0] w);
		return (w == 36'd0) ? 64'd1 : {28'd0, w};
	endfunction

	function automatic logic [47:0] rate_over(logic [47:0] delta, logic [61:0] dt);
		logic [127:0] num;
		logic [127:0] q;
		num = ({80'd0, delta} * 128'd1000000) << 16;
		q = num / {66'd0, dt};
		return (q > {80'd0, RateMax}) ? RateMax : q[47:0];
	endfunction

	function automatic logic [63:0] decay_q16(logic [61:0] dt, logic [63:0] w);
		logic [63:0] x, y, f, p, n;
		if ({2'b0, dt} >= (w << 3))
			return 64'd0;
		x = ({2'b0, dt} << 17) / w;
		y = (x * 64'd94548 + 64'd32768) >> 16;
		n = y >> 16;
		f = y & 64'hFFFF;
		p = 64'd87;
		p = 64'd630 - ((f * p) >> 16);
		p = 64'd3638 - ((f * p) >> 16);
		p = 64'd15744 - ((f * p) >> 16);
		p = 64'd45426 - ((f * p) >> 16);
		p = 64'd65536 - ((f * p) >> 16);
		if (n > 64'd16)
			return 64'd0;
		return p >> n;
	endfunction

	task automatic predict_sample(input logic [47:0] cnt, input logic [61:0] t);
		mwer_pkg::status_t st;
		logic [61:0] dt;
		logic [47:0] delta;
		logic [63:0] d, acc;
		logic        rdy;
		rate_word_t  wd;
		if (!seen) begin
			seen = 1'b1;
			last_count = cnt;
			last_time = t;
			start_time = t;
			st = mwer_pkg::ST_FIRST;
		end else if (t <= last_time) begin
			st = mwer_pkg::ST_STALE;
		end else begin
			dt = t - last_time;
			delta = ((cnt ^ SignBit) > (last_count ^ SignBit)) ?
				(cnt ^ SignBit) - (last_count ^ SignBit) : 48'd0;
			inst_rate = rate_over(delta, dt);
			last_count = cnt;
			last_time = t;
			for (int w = 0; w < NWin; w++) begin
				d = decay_q16(dt, eff_len(win_len[w]));
				acc = {16'd0, inst_rate} * (64'd65536 - d) + {16'd0, avg_rate[w]} * d
					+ 64'd32768;
				avg_rate[w] = acc[63:16];
			end
			st = mwer_pkg::ST_UPDATED;
		end
		for (int w = 0; w < NWin; w++) begin
			rdy = ({2'b0, start_time} + eff_len(win_len[w])) <= {2'b0, t};
			wd.window_index = w[1:0];
			wd.window_rate = rdy ? avg_rate[w] : 48'd0;
			wd.rate_ready = rdy;
			wd.instant_rate = inst_rate;
			wd.sample_status = st;
			wd.last_of_run = (w == NWin - 1);
			expected_words.push_back(wd);
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] a);
		if (e !== a) begin
			$error("%s: expected %0d, got %0d", name, e, a);
			fails++;
		end
	endtask

	task automatic check_word();
		rate_word_t e;
		if (expected_words.size() == 0) begin
			$error("result word with nothing expected");
			fails++;
		end else begin
			e = expected_words.pop_front();
			check_field("window_index", e.window_index, out_ch.window_index);
			check_field("window_rate", e.window_rate, out_ch.window_rate);
			check_field("rate_ready", e.rate_ready, out_ch.rate_ready);
			check_field("instant_rate", e.instant_rate, out_ch.instant_rate);
			check_field("sample_status", e.sample_status, out_ch.sample_status);
			check_field("last_of_run", e.last_of_run, out_ch.last_of_run);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_words.delete();
			win_len[0] = mwer_pkg::WinReset0;
			win_len[1] = mwer_pkg::WinReset1;
			win_len[2] = mwer_pkg::WinReset2;
			win_len[3] = mwer_pkg::WinReset3;
			seen = 1'b0;
			last_count = '0;
			last_time = '0;
			start_time = '0;
			inst_rate = '0;
			for (int w = 0; w < NWin; w++)
				avg_rate[w] = '0;
			fails = 0;
			n_samples = 0;
			n_words = 0;
		end else begin
			if (cfg_we && cfg_idx < mwer_pkg::NumCfg)
				win_len[cfg_idx] = cfg_data;
			if (in_ch.valid && in_ch.ready) begin
				predict_sample(in_ch.sample_count, in_ch.sample_time_us);
				n_samples++;
			end
			if (out_ch.valid && out_ch.ready) begin
				check_word();
				n_words++;
			end
		end
		pending = expected_words.size();
	end
endmodule

// ===== tb/multi_window_ema_rate_meter_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// multi_window_ema_rate_meter_tb
// Drives counter samples into the rate meter under four idle/stall mixes and
// several window settings (zero, one, maximum, reset values); the checker
// beside the block predicts every result word and counts mismatches.
// ---------------------------------------------------------------------------
module multi_window_ema_rate_meter_tb;
	localparam int WatchLimit = 20000;
	localparam int HoldCycles = 400;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [mwer_pkg::CfgIdxW-1:0] cfg_idx;
	logic [mwer_pkg::WinW-1:0] cfg_data;
	int fails, pending, n_samples, n_words;
	int send_idle, recv_stall, quiet;
	bit hold_req;
	bit hold_done;
	logic [61:0] cur_t;
	logic [47:0] cur_c;

	mwer_in_if  in_ch ();
	mwer_out_if out_ch ();

	multi_window_ema_rate_meter dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	mwer_checker u_checker (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.fails(fails), .pending(pending), .n_samples(n_samples), .n_words(n_words)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !arst_n)
			quiet <= 0;
		else if (quiet >= WatchLimit) begin
			$display("tb: failure");
			$finish;
		end else
			quiet <= quiet + 1;
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (HoldCycles) @(negedge clk);
			end
			out_ch.ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	task automatic send(input logic [47:0] c, input logic [61:0] t);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.sample_count <= c;
		in_ch.sample_time_us <= t;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_windows(input logic [35:0] w0, input logic [35:0] w1,
		input logic [35:0] w2, input logic [35:0] w3);
		logic [35:0] v[4];
		v = '{w0, w1, w2, w3};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= i[mwer_pkg::CfgIdxW-1:0];
			cfg_data <= v[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_advance(input logic [47:0] c, input logic [61:0] dt);
		cur_t = cur_t + dt;
		cur_c = c;
		send(c, cur_t);
	endtask

	task automatic random_sample();
		logic [63:0] r64;
		logic [61:0] dt;
		logic [47:0] c;
		int k;
		r64 = {$urandom, $urandom};
		k = $urandom_range(99);
		if (k < 8) begin
			send(r64[47:0], 62'(r64[61:0] % ({2'b0, cur_t} + 64'd1)));
		end else begin
			case ($urandom_range(9))
				0, 1, 2: dt = 62'($urandom_range(1, 1000));
				3, 4, 5: dt = 62'($urandom_range(1, 1 << 24));
				6, 7:    dt = {28'd0, r64[33:0]} + 62'd1;
				8:       dt = {22'd0, r64[39:0]} + 62'd1;
				default: dt = 62'($urandom_range(1, 100000000));
			endcase
			k = $urandom_range(99);
			if (k < 10)
				c = cur_c - $urandom;
			else if (k < 16)
				c = r64[63:16];
			else if (k < 30)
				c = cur_c + {16'd0, $urandom};
			else
				c = cur_c + $urandom_range(0, 1 << 20);
			send_advance(c, dt);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.sample_count = '0;
		in_ch.sample_time_us = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		hold_req = 1'b0;
		send_idle = 0;
		recv_stall = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: first sample, stale, saturation, decrease, window edges
		cur_t = '0;
		cur_c = 48'h8000_0000_0000;
		send(cur_c, cur_t);
		send(48'd0, 62'd0);
		send_advance(48'h7FFF_FFFF_FFFF, 62'd1);
		send_advance(48'd100, 62'd1);
		send_advance(48'd1100, 62'd1000);
		send_advance(48'd5000000, 62'd60000000 - cur_t);
		send(48'd5000005, cur_t - 62'd1);
		send_advance(cur_c, 62'd300000000 - cur_t);
		send_advance(cur_c + 48'd123456789, 62'd900000000 - cur_t);
		send_advance(cur_c + 48'h100_0000_0000, 62'd3600000000 - cur_t);
		send_advance(cur_c + 48'd7, 62'd28800000000);
		send_advance(cur_c + 48'd7, 62'd28799999999);
		wait_idle();
		write_windows(36'd0, 36'd1, 36'hF_FFFF_FFFF, 36'd12345);
		send_advance(cur_c + 48'd1, 62'd1);
		send_advance(cur_c + 48'd99, 62'd8);
		send_advance(cur_c + 48'd99, 62'd98760);
		send_advance(cur_c + 48'hFFFF, 62'h7_FFFF_FFFF);

		for (int ph = 0; ph < 4; ph++) begin
			wait_idle();
			case (ph)
				0: write_windows(36'd1, 36'd1000, 36'd1000000, 36'd1000000000);
				1: write_windows(36'hF_FFFF_FFFF, 36'd0, 36'd50, 36'd7777777);
				2: write_windows(36'({$urandom_range(15), $urandom}), 36'($urandom),
					36'($urandom_range(1, 1 << 20)), 36'({$urandom_range(15), $urandom}));
				default: write_windows(mwer_pkg::WinReset0, mwer_pkg::WinReset1,
					mwer_pkg::WinReset2, mwer_pkg::WinReset3);
			endcase
			case (ph)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 85; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 85; end
				default: begin send_idle = 22; recv_stall = 22; end
			endcase
			for (int i = 0; i < 25; i++) begin
				if (ph == 0 && i == 5)
					hold_req = 1'b1;
				if (ph == 1 && i == 14) begin
					in_ch.valid <= 1'b0;
					@(negedge clk);
					while (pending != 0) @(negedge clk);
				end
				random_sample();
			end
		end

		// top of the time range, then stale samples spread over all of it
		send_advance(cur_c + 48'd1000, 62'h3FFF_FFFF_FFFF_FFFF - cur_t);
		for (int i = 0; i < 6; i++)
			send(48'({$urandom, $urandom}), 62'({$urandom, $urandom}));
		send(48'h7FFF_FFFF_FFFF, 62'h3FFF_FFFF_FFFF_FFFF);

		in_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (50) @(posedge clk);
		if (pending != 0)
			$error("%0d result words never arrived", pending);
		$display("tb: %0d samples, %0d result words; four idle mixes, window lengths 0 to max",
			n_samples, n_words);
		if (fails == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
